// File: rtl/core/mjs_pkg.sv
// Shared types, codes and helper functions of the multicore job scheduler.
`timescale 1ns / 1ps
package mjs_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_FINISH = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    localparam logic [2:0] POL_FCFS = 3'd0;
    localparam logic [2:0] POL_SJF  = 3'd1;
    localparam logic [2:0] POL_PSJF = 3'd2;
    localparam logic [2:0] POL_PRI  = 3'd3;
    localparam logic [2:0] POL_PPRI = 3'd4;
    localparam logic [2:0] POL_RR   = 3'd5;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_CORES  = 2'd1;

    typedef enum logic [5:0] {
        S_IDLE, S_A_FREE, S_A_IDLE, S_A_RUN, S_A_ENQ,
        S_P_RC, S_P_RE, S_P_CMP, S_P_WRN, S_P_LD, S_P_WRD,
        S_Q0, S_Q_RO, S_Q_RE, S_Q_CMP, S_Q_SH, S_Q_SW, S_Q_INS,
        S_D_SH, S_D_SW,
        S_F_RD, S_F_CMP, S_F_T, S_F_S, S_F_W, S_F_QR, S_F_QC,
        S_F_C0, S_F_CR, S_F_CC, S_F_END,
        S_X0, S_X_RE, S_X_LD, S_X_WR,
        S_DISP, S_DP_RO, S_DP_RD, S_DP_LD, S_DP_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] job;
        logic [31:0] arrival;
        logic [15:0] length;
        logic [15:0] remain;
        logic [15:0] urgency;
        logic [31:0] first_run;
        logic        started;
        logic [31:0] last_start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add32 = s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
    endfunction

    function automatic logic [15:0] left_now(logic [15:0] remain, logic [31:0] last,
                                             logic [31:0] now);
        logic [31:0] ran;
        begin
            ran = now - last;
            left_now = (ran >= {16'd0, remain}) ? 16'd0 : remain - ran[15:0];
        end
    endfunction

    // true when a is strictly ahead of b in queue order
    function automatic logic ahead(logic [2:0] pol, t_entry a, t_entry b);
        logic [15:0] ka;
        logic [15:0] kb;
        begin
            ka = a.urgency;
            kb = b.urgency;
            case (pol)
                POL_SJF: begin
                    ka = a.length;
                    kb = b.length;
                end
                POL_PSJF: begin
                    ka = a.remain;
                    kb = b.remain;
                end
                default: ;
            endcase
            if (pol == POL_RR)
                ahead = 1'b0;
            else if (pol == POL_FCFS || ka == kb)
                ahead = a.arrival < b.arrival;
            else
                ahead = ka < kb;
        end
    endfunction

endpackage

// File: rtl/core/multicore_job_scheduler.sv
// Multicore job scheduler top level: job table, ordered ready queue and core map.
// One request is taken at a time and processed by a sequencer over a shared compare
// and subtract datapath; the block is not ready until the request has been worked
// through, and a finished result waits in an output register while the next request
// is taken. Each table, queue or core element is visited in turn.
// Arrival: a search of the table for a free entry, a search of the active cores for an
// idle one, a preemption search over the cores (preemptive policies only), then an
// ordered insert that compares queued jobs and shifts those behind. Finish: a search of
// the table entries, a search of the queue, a pass over every core, then a dispatch
// from the queue head. An unused opcode goes straight to the result.
module multicore_job_scheduler
    import mjs_pkg::*;
#(
    parameter int MAX_CORES = 8,
    parameter int MAX_JOBS  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // opcode[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    // job_id[15:0], now[47:16], run_length[63:48], priority_req[79:64], core[82:80],
    // zero fill
    input  logic [87:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // assigned[0], core_index[3:1], next_job[19:4], error[20], total_waiting[52:21],
    // total_turnaround[84:53], total_response[116:85], jobs_done[132:117], zero fill
    output logic [135:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [3:0]   i_cfg_data
);
    localparam int CW = MAX_CORES > 1 ? $clog2(MAX_CORES) : 1;
    localparam int EW = $clog2(MAX_JOBS);
    localparam int QW = $clog2(MAX_JOBS + 1);

    t_state r_state, n_state, r_qret, r_dret;

    logic [2:0]           r_policy;
    logic [3:0]           r_active;
    logic [MAX_JOBS-1:0]  r_valid;
    logic [MAX_CORES-1:0] r_busy;
    logic [QW-1:0]        r_count;

    logic [15:0] r_job, r_len, r_urg;
    logic [31:0] r_now;
    logic [2:0]  r_core;

    t_entry         r_w;
    logic [EW-1:0]  r_e, r_i, r_rr, r_went;
    logic [QW-1:0]  r_j, r_pos;
    logic [CW-1:0]  r_c, r_worst;
    logic           r_worst_v;
    logic [15:0]    r_wkey;
    logic [31:0]    r_warr;

    logic [31:0] r_turn, r_resp, r_wait;
    logic [31:0] r_sum_wait, r_sum_turn, r_sum_resp;
    logic [15:0] r_done;

    logic        r_asg, r_err;
    logic [2:0]  r_cidx;
    logic [15:0] r_next;
    logic        r_ov;
    logic [135:0] r_odata;

    logic [EW-1:0]      ent_rd_addr, ent_wr_addr;
    logic               ent_we;
    logic [ENTRY_W-1:0] ent_wr_data, ent_rd_data;
    logic [EW-1:0]      ro_rd_addr, ro_wr_addr, ro_wr_data, ro_rd_data;
    logic               ro_we;
    logic [CW-1:0]      co_rd_addr, co_wr_addr;
    logic [EW-1:0]      co_wr_data, co_rd_data;
    logic               co_we;

    t_entry      rec, run_w, ld_w, pre_w, disp_w;
    logic [2:0]  w_pol;
    logic [6:0]  w_lim;
    logic        w_last_c, w_cr_ok, w_take, w_ahead;
    logic [CW-1:0] w_cr;
    logic [15:0] w_left, w_key, w_newkey;
    t_opcode     w_op;

    mjs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_JOBS)) u_entry_ram (
        .i_clk(i_clk), .i_we(ent_we), .i_wr_addr(ent_wr_addr), .i_wr_data(ent_wr_data),
        .i_rd_addr(ent_rd_addr), .o_rd_data(ent_rd_data)
    );
    mjs_ram #(.WIDTH(EW), .DEPTH(MAX_JOBS)) u_queue_ram (
        .i_clk(i_clk), .i_we(ro_we), .i_wr_addr(ro_wr_addr), .i_wr_data(ro_wr_data),
        .i_rd_addr(ro_rd_addr), .o_rd_data(ro_rd_data)
    );
    mjs_ram #(.WIDTH(EW), .DEPTH(MAX_CORES)) u_core_ram (
        .i_clk(i_clk), .i_we(co_we), .i_wr_addr(co_wr_addr), .i_wr_data(co_wr_data),
        .i_rd_addr(co_rd_addr), .o_rd_data(co_rd_data)
    );

    always_comb begin
        rec      = t_entry'(ent_rd_data);
        w_op     = t_opcode'(i_s_axis_tuser);
        w_pol    = (r_policy > POL_RR) ? POL_FCFS : r_policy;
        if (r_active == 4'd0)
            w_lim = 7'd1;
        else if (7'(r_active) > 7'(MAX_CORES))
            w_lim = 7'(MAX_CORES);
        else
            w_lim = 7'(r_active);
        w_last_c = (7'(r_c) == w_lim - 7'd1);
        w_cr_ok  = (7'(r_core) < w_lim);
        w_cr     = CW'(r_core);
        w_left   = left_now(rec.remain, rec.last_start, r_now);
        w_key    = (w_pol == POL_PSJF) ? w_left : rec.urgency;
        w_newkey = (w_pol == POL_PSJF) ? r_w.length : r_w.urgency;
        if (!r_worst_v)
            w_take = w_newkey < w_key;
        else
            w_take = (w_key > r_wkey) || (w_key == r_wkey && rec.arrival > r_warr);
        w_ahead  = ahead(w_pol, r_w, rec);
        run_w            = r_w;
        run_w.started    = 1'b1;
        run_w.first_run  = r_now;
        run_w.last_start = r_now;
        ld_w             = rec;
        ld_w.remain      = w_left;
        pre_w            = ld_w;
        pre_w.started    = (rec.first_run == r_now) ? 1'b0 : rec.started;
        disp_w            = rec;
        disp_w.last_start = r_now;
        if (!rec.started) begin
            disp_w.started   = 1'b1;
            disp_w.first_run = r_now;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (w_op)
                        OP_ARRIVE: n_state = S_A_FREE;
                        OP_FINISH: n_state = S_F_RD;
                        OP_EXPIRE: n_state = S_X0;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_A_FREE: begin
                if (!r_valid[r_i])
                    n_state = S_A_IDLE;
                else if (r_i == EW'(MAX_JOBS - 1))
                    n_state = S_FIN;
            end
            S_A_IDLE: begin
                if (!r_busy[r_c])
                    n_state = S_A_RUN;
                else if (w_last_c)
                    n_state = (w_pol == POL_PSJF || w_pol == POL_PPRI) ? S_P_RC : S_A_ENQ;
            end
            S_A_RUN:  n_state = S_FIN;
            S_A_ENQ:  n_state = S_Q0;
            S_P_RC:   n_state = S_P_RE;
            S_P_RE:   n_state = S_P_CMP;
            S_P_CMP: begin
                if (w_last_c)
                    n_state = (r_worst_v || w_take) ? S_P_WRN : S_A_ENQ;
                else
                    n_state = S_P_RC;
            end
            S_P_WRN:  n_state = S_P_LD;
            S_P_LD:   n_state = S_P_WRD;
            S_P_WRD:  n_state = S_Q0;
            S_Q0: begin
                if (r_count >= QW'(MAX_JOBS))
                    n_state = r_qret;
                else if (w_pol == POL_RR || r_count == '0)
                    n_state = S_Q_SH;
                else
                    n_state = S_Q_RO;
            end
            S_Q_RO:   n_state = S_Q_RE;
            S_Q_RE:   n_state = S_Q_CMP;
            S_Q_CMP: begin
                if (w_ahead || QW'(r_i) == r_count - 1'b1)
                    n_state = S_Q_SH;
                else
                    n_state = S_Q_RO;
            end
            S_Q_SH:   n_state = (r_j == r_pos) ? S_Q_INS : S_Q_SW;
            S_Q_SW:   n_state = S_Q_SH;
            S_Q_INS:  n_state = r_qret;
            S_D_SH:   n_state = (QW'(r_j + 1'b1) >= r_count) ? r_dret : S_D_SW;
            S_D_SW:   n_state = S_D_SH;
            S_F_RD:   n_state = S_F_CMP;
            S_F_CMP: begin
                if (r_valid[r_i] && rec.job == r_job)
                    n_state = S_F_T;
                else if (r_i == EW'(MAX_JOBS - 1))
                    n_state = S_FIN;
                else
                    n_state = S_F_RD;
            end
            S_F_T:    n_state = S_F_S;
            S_F_S:    n_state = S_F_W;
            S_F_W:    n_state = (r_count == '0) ? S_F_C0 : S_F_QR;
            S_F_QR:   n_state = S_F_QC;
            S_F_QC: begin
                if (ro_rd_data == r_e)
                    n_state = S_D_SH;
                else if (QW'(r_i) == r_count - 1'b1)
                    n_state = S_F_C0;
                else
                    n_state = S_F_QR;
            end
            S_F_C0:   n_state = S_F_CR;
            S_F_CR:   n_state = S_F_CC;
            S_F_CC:   n_state = (r_c == CW'(MAX_CORES - 1)) ? S_F_END : S_F_CR;
            S_F_END:  n_state = (w_cr_ok && !r_busy[w_cr]) ? S_DISP : S_FIN;
            S_X0: begin
                if (!w_cr_ok)
                    n_state = S_FIN;
                else if (r_busy[w_cr])
                    n_state = S_X_RE;
                else
                    n_state = S_DISP;
            end
            S_X_RE:   n_state = S_X_LD;
            S_X_LD:   n_state = S_X_WR;
            S_X_WR:   n_state = S_Q0;
            S_DISP:   n_state = (r_count == '0) ? S_FIN : S_DP_RO;
            S_DP_RO:  n_state = S_D_SH;
            S_DP_RD:  n_state = S_DP_LD;
            S_DP_LD:  n_state = S_DP_WR;
            S_DP_WR:  n_state = S_FIN;
            S_FIN:    n_state = (!r_ov || i_m_axis_tready) ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        o_cfg_ready     = 1'b1;
        ent_rd_addr = '0;
        ent_we      = 1'b0;
        ent_wr_addr = r_e;
        ent_wr_data = r_w;
        ro_rd_addr  = '0;
        ro_we       = 1'b0;
        ro_wr_addr  = EW'(r_j);
        ro_wr_data  = ro_rd_data;
        co_rd_addr  = r_c;
        co_we       = 1'b0;
        co_wr_addr  = r_c;
        co_wr_data  = r_e;
        case (r_state)
            S_A_RUN: begin
                ent_we = 1'b1;
                co_we  = 1'b1;
            end
            S_A_ENQ, S_P_WRD, S_X_WR, S_DP_WR: begin
                ent_we = 1'b1;
                if (r_state == S_DP_WR) begin
                    co_we      = 1'b1;
                    co_wr_addr = w_cr;
                end
            end
            S_P_RE:  ent_rd_addr = co_rd_data;
            S_P_WRN: begin
                ent_we      = 1'b1;
                ent_wr_data = run_w;
                ent_rd_addr = r_went;
                co_we       = 1'b1;
                co_wr_addr  = r_worst;
            end
            S_Q_RO:  ro_rd_addr = r_i;
            S_Q_RE:  ent_rd_addr = ro_rd_data;
            S_Q_SH:  ro_rd_addr = EW'(r_j - 1'b1);
            S_Q_SW:  ro_we = 1'b1;
            S_Q_INS: begin
                ro_we      = 1'b1;
                ro_wr_addr = EW'(r_pos);
                ro_wr_data = r_e;
            end
            S_D_SH:  ro_rd_addr = EW'(r_j + 1'b1);
            S_D_SW:  ro_we = 1'b1;
            S_F_RD:  ent_rd_addr = r_i;
            S_F_QR:  ro_rd_addr = r_i;
            S_X0:    co_rd_addr = w_cr;
            S_X_RE:  ent_rd_addr = co_rd_data;
            S_DP_RD: ent_rd_addr = r_e;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_qret     <= S_FIN;
            r_dret     <= S_FIN;
            r_policy   <= POL_FCFS;
            r_active   <= 4'd1;
            r_valid    <= '0;
            r_busy     <= '0;
            r_count    <= '0;
            r_sum_wait <= '0;
            r_sum_turn <= '0;
            r_sum_resp <= '0;
            r_done     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POLICY: r_policy <= i_cfg_data[2:0];
                    CFG_CORES:  r_active <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_FIN && (!r_ov || i_m_axis_tready))
                r_ov <= 1'b1;
            else if (r_ov && i_m_axis_tready)
                r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_job  <= i_s_axis_tdata[15:0];
                        r_now  <= i_s_axis_tdata[47:16];
                        r_len  <= i_s_axis_tdata[63:48];
                        r_urg  <= i_s_axis_tdata[79:64];
                        r_core <= i_s_axis_tdata[82:80];
                        r_asg  <= 1'b0;
                        r_cidx <= 3'd0;
                        r_next <= 16'd0;
                        r_err  <= 1'b0;
                        r_i    <= '0;
                    end
                end
                S_A_FREE: begin
                    if (!r_valid[r_i]) begin
                        r_valid[r_i] <= 1'b1;
                        r_e          <= r_i;
                        r_c          <= '0;
                        r_w          <= '{job: r_job, arrival: r_now, length: r_len,
                                          remain: r_len, urgency: r_urg, first_run: 32'd0,
                                          started: 1'b0, last_start: r_now};
                    end else if (r_i == EW'(MAX_JOBS - 1)) begin
                        r_err <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_A_IDLE: begin
                    if (!r_busy[r_c]) begin
                        r_w <= run_w;
                    end else if (w_last_c) begin
                        r_c       <= '0;
                        r_worst_v <= 1'b0;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_A_RUN: begin
                    r_busy[r_c] <= 1'b1;
                    r_asg       <= 1'b1;
                    r_cidx      <= 3'(r_c);
                end
                S_A_ENQ:  r_qret <= S_FIN;
                S_P_RE:   r_rr <= co_rd_data;
                S_P_CMP: begin
                    if (w_take) begin
                        r_worst_v <= 1'b1;
                        r_worst   <= r_c;
                        r_wkey    <= w_key;
                        r_warr    <= rec.arrival;
                        r_went    <= r_rr;
                    end
                    if (!w_last_c)
                        r_c <= r_c + 1'b1;
                end
                S_P_WRN: begin
                    r_asg  <= 1'b1;
                    r_cidx <= 3'(r_worst);
                end
                S_P_LD: begin
                    r_w    <= pre_w;
                    r_e    <= r_went;
                    r_qret <= S_FIN;
                end
                S_Q0: begin
                    r_i   <= '0;
                    r_pos <= r_count;
                    r_j   <= r_count;
                end
                S_Q_CMP: begin
                    if (w_ahead)
                        r_pos <= QW'(r_i);
                    else
                        r_i <= r_i + 1'b1;
                end
                S_Q_SW:   r_j <= r_j - 1'b1;
                S_Q_INS:  r_count <= r_count + 1'b1;
                S_D_SH: begin
                    if (QW'(r_j + 1'b1) >= r_count)
                        r_count <= r_count - 1'b1;
                end
                S_D_SW:   r_j <= r_j + 1'b1;
                S_F_CMP: begin
                    if (r_valid[r_i] && rec.job == r_job) begin
                        r_w <= rec;
                        r_e <= r_i;
                    end else if (r_i == EW'(MAX_JOBS - 1)) begin
                        r_err <= 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_F_T: begin
                    r_turn <= r_now - r_w.arrival;
                    r_resp <= (r_w.started ? r_w.first_run : r_now) - r_w.arrival;
                end
                S_F_S: begin
                    r_sum_turn <= sat_add32(r_sum_turn, r_turn);
                    r_sum_resp <= sat_add32(r_sum_resp, r_resp);
                    r_wait     <= (r_turn >= {16'd0, r_w.length})
                                  ? r_turn - {16'd0, r_w.length} : 32'd0;
                    if (r_done != 16'hFFFF)
                        r_done <= r_done + 1'b1;
                end
                S_F_W: begin
                    r_sum_wait <= sat_add32(r_sum_wait, r_wait);
                    r_i        <= '0;
                end
                S_F_QC: begin
                    if (ro_rd_data == r_e) begin
                        r_j    <= QW'(r_i);
                        r_dret <= S_F_C0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_F_C0:   r_c <= '0;
                S_F_CC: begin
                    if (r_busy[r_c] && co_rd_data == r_e)
                        r_busy[r_c] <= 1'b0;
                    if (r_c != CW'(MAX_CORES - 1))
                        r_c <= r_c + 1'b1;
                end
                S_F_END:  r_valid[r_e] <= 1'b0;
                S_X_RE:   r_e <= co_rd_data;
                S_X_LD: begin
                    r_w          <= ld_w;
                    r_busy[w_cr] <= 1'b0;
                end
                S_X_WR:   r_qret <= S_DISP;
                S_DP_RO: begin
                    r_e    <= ro_rd_data;
                    r_j    <= '0;
                    r_dret <= S_DP_RD;
                end
                S_DP_LD:  r_w <= disp_w;
                S_DP_WR: begin
                    r_busy[w_cr] <= 1'b1;
                    r_asg        <= 1'b1;
                    r_next       <= r_w.job;
                end
                S_FIN: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_odata <= {3'd0, r_done, r_sum_resp, r_sum_turn, r_sum_wait,
                                    r_err, r_next, r_cidx, r_asg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    a_queue_le_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= $countones(r_valid))
        else $error("ready queue longer than job table");

    a_err_not_asg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !(r_err && r_asg))
        else $error("result both assigned and in error");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ov || i_m_axis_tready)) |=> o_m_axis_tvalid)
        else $error("finished request not presented");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == S_Q_INS || $past(r_state) == S_D_SH || $past(!i_rst_n)))
        else $error("queue count changed outside insert or remove");

endmodule

// File: rtl/core/mjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the multicore job scheduler with its own scheduling model.
`timescale 1ns / 1ps
module tb;
    import mjs_pkg::*;

    localparam int NCORE = 8;
    localparam int NJOB  = 64;
    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] job_id;
        logic [31:0] now;
        logic [15:0] run_length;
        logic [15:0] priority_req;
        logic [2:0]  core;
    } t_req;

    // fields from the highest bit down, so assigned lands in bit 0
    typedef struct packed {
        logic [15:0] jobs_done;
        logic [31:0] total_response;
        logic [31:0] total_turnaround;
        logic [31:0] total_waiting;
        logic        error;
        logic [15:0] next_job;
        logic [2:0]  core_index;
        logic        assigned;
    } t_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [1:0]   i_s_axis_tuser;
    logic [87:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [135:0] o_m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [3:0]   i_cfg_data;

    multicore_job_scheduler dut (.*);

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // scheduler model
    logic [2:0]  m_policy;
    logic [3:0]  m_cores;
    logic        j_valid [NJOB];
    logic [15:0] j_job [NJOB];
    logic [31:0] j_arr [NJOB];
    logic [15:0] j_len [NJOB];
    logic [15:0] j_left [NJOB];
    logic [15:0] j_urg [NJOB];
    logic [31:0] j_first [NJOB];
    logic        j_started [NJOB];
    logic [31:0] j_last [NJOB];
    int          ready_q[$];
    logic        c_busy [NCORE];
    int          c_job [NCORE];
    logic [31:0] s_wait, s_turn, s_resp;
    logic [15:0] s_done;

    t_res sched_expected[$];
    int   errors = 0;
    int   cycles = 0;
    bit   settle = 0;
    logic [31:0] clock_now = 0;

    function automatic logic [2:0] pol_eff();
        return (m_policy > POL_RR) ? POL_FCFS : m_policy;
    endfunction

    function automatic int ncores();
        if (m_cores == 0) return 1;
        if (m_cores > NCORE) return NCORE;
        return m_cores;
    endfunction

    function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] rem_at(int e, logic [31:0] t);
        logic [31:0] ran;
        ran = t - j_last[e];
        return (ran >= {16'd0, j_left[e]}) ? 16'd0 : j_left[e] - ran[15:0];
    endfunction

    function automatic bit beats(int a, int b);
        logic [2:0]  p;
        logic [15:0] ka, kb;
        p = pol_eff();
        if (p == POL_RR) return 0;
        if (p == POL_FCFS) return j_arr[a] < j_arr[b];
        if (p == POL_SJF) begin
            ka = j_len[a]; kb = j_len[b];
        end else if (p == POL_PSJF) begin
            ka = j_left[a]; kb = j_left[b];
        end else begin
            ka = j_urg[a]; kb = j_urg[b];
        end
        if (ka != kb) return ka < kb;
        return j_arr[a] < j_arr[b];
    endfunction

    function automatic void queue_insert(int e);
        int pos;
        pos = ready_q.size();
        for (int i = 0; i < ready_q.size(); i++)
            if (beats(e, ready_q[i])) begin
                pos = i;
                break;
            end
        ready_q.insert(pos, e);
    endfunction

    function automatic void start_on(int c, int e, logic [31:0] t);
        if (!j_started[e]) begin
            j_started[e] = 1;
            j_first[e] = t;
        end
        j_last[e] = t;
        c_busy[c] = 1;
        c_job[c] = e;
    endfunction

    function automatic void dispatch_head(int c, logic [31:0] t, ref t_res r);
        int e;
        if (ready_q.size() == 0) return;
        e = ready_q.pop_front();
        start_on(c, e, t);
        r.assigned = 1;
        r.next_job = j_job[e];
    endfunction

    function automatic void sched_reset();
        m_policy = POL_FCFS;
        m_cores = 1;
        for (int i = 0; i < NJOB; i++) j_valid[i] = 0;
        for (int c = 0; c < NCORE; c++) c_busy[c] = 0;
        ready_q.delete();
        s_wait = 0; s_turn = 0; s_resp = 0; s_done = 0;
    endfunction

    function automatic t_res sched_step(t_req q);
        t_res r;
        int e, n, worst, dd;
        logic [2:0] p;
        logic [31:0] t, turn, resp, wkey, k, nk;
        r = '0;
        t = q.now;
        n = ncores();
        p = pol_eff();
        case (t_opcode'(q.opcode))
            OP_ARRIVE: begin
                e = -1;
                for (int i = 0; i < NJOB; i++)
                    if (!j_valid[i]) begin
                        e = i;
                        break;
                    end
                if (e < 0) r.error = 1;
                else begin
                    j_valid[e] = 1; j_job[e] = q.job_id; j_arr[e] = t;
                    j_len[e] = q.run_length; j_left[e] = q.run_length;
                    j_urg[e] = q.priority_req; j_started[e] = 0; j_first[e] = 0;
                    j_last[e] = t;
                    worst = -2;
                    for (int c = 0; c < n; c++)
                        if (!c_busy[c]) begin
                            start_on(c, e, t);
                            r.assigned = 1;
                            r.core_index = 3'(c);
                            worst = -3;
                            break;
                        end
                    if (worst == -2) begin
                        worst = -1;
                        wkey = 0;
                        if (p == POL_PSJF || p == POL_PPRI) begin
                            nk = (p == POL_PSJF) ? j_len[e] : j_urg[e];
                            for (int c = 0; c < n; c++) begin
                                k = (p == POL_PSJF) ? rem_at(c_job[c], t) : j_urg[c_job[c]];
                                if (worst < 0) begin
                                    if (nk < k) begin
                                        worst = c; wkey = k;
                                    end
                                end else if (k > wkey || (k == wkey &&
                                             j_arr[c_job[c]] > j_arr[c_job[worst]])) begin
                                    worst = c; wkey = k;
                                end
                            end
                        end
                        if (worst >= 0) begin
                            dd = c_job[worst];
                            j_left[dd] = rem_at(dd, t);
                            if (j_first[dd] == t) j_started[dd] = 0;
                            start_on(worst, e, t);
                            queue_insert(dd);
                            r.assigned = 1;
                            r.core_index = 3'(worst);
                        end else queue_insert(e);
                    end
                end
            end
            OP_FINISH: begin
                e = -1;
                for (int i = 0; i < NJOB; i++)
                    if (j_valid[i] && j_job[i] == q.job_id) begin
                        e = i;
                        break;
                    end
                if (e < 0) r.error = 1;
                else begin
                    turn = t - j_arr[e];
                    resp = (j_started[e] ? j_first[e] : t) - j_arr[e];
                    s_wait = sadd(s_wait, turn >= j_len[e] ? turn - j_len[e] : 0);
                    s_turn = sadd(s_turn, turn);
                    s_resp = sadd(s_resp, resp);
                    if (s_done != 16'hFFFF) s_done++;
                    for (int i = 0; i < ready_q.size(); i++)
                        if (ready_q[i] == e) begin
                            ready_q.delete(i);
                            break;
                        end
                    for (int c = 0; c < NCORE; c++)
                        if (c_busy[c] && c_job[c] == e) c_busy[c] = 0;
                    j_valid[e] = 0;
                    if (q.core < n && !c_busy[q.core]) dispatch_head(q.core, t, r);
                end
            end
            OP_EXPIRE: begin
                if (q.core < n) begin
                    if (c_busy[q.core]) begin
                        e = c_job[q.core];
                        j_left[e] = rem_at(e, t);
                        c_busy[q.core] = 0;
                        queue_insert(e);
                    end
                    dispatch_head(q.core, t, r);
                end
            end
            default: ;
        endcase
        r.total_waiting = s_wait;
        r.total_turnaround = s_turn;
        r.total_response = s_resp;
        r.jobs_done = s_done;
        return r;
    endfunction

    // sender idling
    task automatic idle_gap();
        if (!settle && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    task automatic send_req(t_req q);
        idle_gap();
        i_s_axis_tdata <= {5'd0, q.core, q.priority_req, q.run_length, q.now, q.job_id};
        i_s_axis_tuser <= q.opcode;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sched_expected.push_back(sched_step(q));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        i_s_axis_tvalid <= 1'b0;
        while (sched_expected.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_POLICY) m_policy = val[2:0];
        else m_cores = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result check
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_res'(o_m_axis_tdata[132:0]);
            if (sched_expected.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
            end else begin
                want = sched_expected.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %h actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (settle || $urandom_range(0, 2) != 0) i_m_axis_tready <= 1'b1;
        else begin
            i_m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_req mk(logic [1:0] op, logic [15:0] id, logic [31:0] t,
                                logic [15:0] len, logic [15:0] pr, logic [2:0] c);
        t_req q;
        q.opcode = op; q.job_id = id; q.now = t; q.run_length = len;
        q.priority_req = pr; q.core = c;
        return q;
    endfunction

    // random well-formed traffic: mostly known jobs and active cores
    task automatic random_phase(int count);
        t_req q;
        int e;
        for (int i = 0; i < count; i++) begin
            clock_now += $urandom_range(0, 40);
            q = mk(OP_ARRIVE, 16'($urandom_range(0, 300)), clock_now,
                   16'($urandom_range(0, 200)), 16'($urandom_range(0, 30)),
                   3'($urandom_range(0, ncores() - 1)));
            case ($urandom_range(0, 19))
                0: q.opcode = OP_NONE;
                1: q = mk(2'($urandom), 16'($urandom), $urandom, 16'($urandom),
                          16'($urandom), 3'($urandom));
                2, 3, 4, 5, 6, 7: begin
                    q.opcode = OP_FINISH;
                    e = $urandom_range(0, NJOB - 1);
                    if (j_valid[e]) q.job_id = j_job[e];
                end
                8, 9, 10, 11: q.opcode = OP_EXPIRE;
                12: begin
                    q.run_length = 16'($urandom);
                    q.priority_req = 16'($urandom);
                end
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0) q.core = 3'($urandom);
            send_req(q);
        end
    endtask

    t_req dir_req [13];
    logic [15:0] dir_job [13];
    logic [1:0]  dir_err [13];

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser = '0;
        i_s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_POLICY;
        i_cfg_data = '0;
        sched_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: opcode, fields; check column (2 = model only, 0/1 error flag)
        dir_req[0]  = mk(OP_FINISH, 16'hFFFF, 32'd5, 0, 0, 0);          dir_err[0] = 1;
        dir_req[1]  = mk(OP_NONE, 16'hFFFF, '1, '1, '1, 3'd7);          dir_err[1] = 0;
        dir_req[2]  = mk(OP_EXPIRE, 0, 0, 0, 0, 3'd0);                  dir_err[2] = 0;
        dir_req[3]  = mk(OP_ARRIVE, 16'hFFFF, 32'd10, 16'hFFFF, 16'hFFFF, 0);
        dir_err[3] = 0;
        dir_req[4]  = mk(OP_ARRIVE, 16'd0, 32'd10, 16'd0, 16'd0, 0);   dir_err[4] = 2;
        dir_req[5]  = mk(OP_ARRIVE, 16'd0, 32'd11, 16'd3, 16'd1, 0);   dir_err[5] = 2;
        dir_req[6]  = mk(OP_EXPIRE, 0, 32'd20, 0, 0, 3'd7);             dir_err[6] = 2;
        dir_req[7]  = mk(OP_EXPIRE, 0, 32'hFFFF_FFF0, 0, 0, 3'd0);      dir_err[7] = 2;
        dir_req[8]  = mk(OP_FINISH, 16'd0, 32'd2, 0, 0, 3'd0);          dir_err[8] = 2;
        dir_req[9]  = mk(OP_FINISH, 16'd0, 32'd30, 0, 0, 3'd0);         dir_err[9] = 2;
        dir_req[10] = mk(OP_FINISH, 16'hFFFF, '1, 0, 0, 3'd0);          dir_err[10] = 2;
        dir_req[11] = mk(OP_FINISH, 16'd0, 32'd40, 0, 0, 3'd6);         dir_err[11] = 1;
        dir_req[12] = mk(OP_EXPIRE, 0, 32'd41, 0, 0, 3'd0);             dir_err[12] = 0;
        for (int i = 0; i < 13; i++) begin
            send_req(dir_req[i]);
            if (dir_err[i] != 2 && sched_expected[$].error !== dir_err[i][0]) begin
                $display("%0t: row %0d expected error %0d actual %0d", $realtime, i,
                         dir_err[i][0], sched_expected[$].error);
                errors++;
            end
        end

        // table full
        for (int i = 0; i < NJOB + 1; i++)
            send_req(mk(OP_ARRIVE, 16'(i), 32'(100 + i), 16'd5, 16'(i), 3'd0));
        for (int i = 0; i < NJOB + 1; i++)
            send_req(mk(OP_FINISH, 16'(i), 32'(200 + i), 16'd0, 16'd0, 3'd0));
        clock_now = 300;

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_POLICY, (ph < 8) ? ph[3:0] : 4'($urandom_range(0, 5)));
            write_reg(CFG_CORES, (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 :
                      (ph == 2) ? 4'd8 : (ph == 3) ? 4'd1 : 4'($urandom_range(1, 8)));
            if (ph == 9) settle = 1;
            random_phase(110);
        end

        i_s_axis_tvalid <= 1'b0;
        while (sched_expected.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule
